### hw/rtl/frlct_pkg.sv
// shared constants and types for the function-range lookup call tracker
package frlct_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] FUNC_SYM_TYPE = 4'd2;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CALL   = 2'd1;
    localparam logic [1:0] OP_RETURN = 2'd2;

    localparam logic signed [15:0] DEPTH_MAX = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_MIN = -16'sh8000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [31:0] name;
        logic [31:0] start;
        logic [31:0] length;
    } entry_t;

endpackage

### hw/rtl/func_range_lookup_call_tracker.sv
// function-range table with sequential first-match lookup and call-depth counter
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_valid / s_ready  | operation, symbol record, target_address, trace_pc
//  m_      | out | m_valid / m_ready  | hit, matched entry, depth_now, pc_echo, load flags
//
//  a load goes through the load state (table write) and done state to the output register
//  a lookup scans the stored entries in order and stops on the first hit or after the last;
//  the scan makes one table read and one 33-bit range compare per cycle, through the single read port
//  s_ready is high only while the sequencer is idle; it goes idle as the result is registered,
//  and a result waiting for m_ready holds the sequencer in its done state
//  reset clears counters and control only; table entries are never read before written,
//  so no clearing pass is run
module func_range_lookup_call_tracker
    import frlct_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_symbol_info_byte,
    input  logic [31:0]        s_symbol_name_offset,
    input  logic [31:0]        s_symbol_start,
    input  logic [31:0]        s_symbol_length,
    input  logic [31:0]        s_target_address,
    input  logic [31:0]        s_trace_pc,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [31:0]        m_hit_name_offset,
    output logic [31:0]        m_hit_start,
    output logic [31:0]        m_hit_length,
    output logic signed [15:0] m_depth_now,
    output logic [31:0]        m_pc_echo,
    output logic               m_stored,
    output logic               m_dropped_full
);

    // sequencer state
    state_t state_reg, state_next;

    // latched input beat (payload, no reset)
    logic [1:0]  op_reg;
    logic [7:0]  info_reg;
    logic [31:0] name_reg;
    logic [31:0] start_reg;
    logic [31:0] length_reg;
    logic [31:0] target_reg;
    logic [31:0] pc_reg;

    // table bookkeeping
    logic [CNT_W-1:0]   used_reg, used_next;
    logic signed [15:0] depth_reg, depth_next;

    // scan pointer and read-data-valid flag
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;

    // table memory with registered read
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // result being built
    logic        res_hit_reg, res_hit_next;
    logic [31:0] res_name_reg, res_name_next;
    logic [31:0] res_start_reg, res_start_next;
    logic [31:0] res_length_reg, res_length_next;
    logic        res_stored_reg, res_stored_next;
    logic        res_dropped_reg, res_dropped_next;

    // output register
    logic               m_valid_reg;
    logic               m_hit_reg;
    logic [31:0]        m_name_reg;
    logic [31:0]        m_start_reg;
    logic [31:0]        m_length_reg;
    logic signed [15:0] m_depth_reg;
    logic [31:0]        m_pc_reg;
    logic               m_stored_reg;
    logic               m_dropped_reg;

    // sequencer outputs
    logic in_accept;
    logic rd_en;
    logic mem_we;
    logic out_load;

    // shared range compare: end formed in 33 bits so it never wraps
    logic [32:0] range_lo;
    logic [32:0] range_hi;
    logic [32:0] target_ext;
    logic        range_hit;
    logic        is_func;
    logic        table_full;

    assign range_lo   = {1'b0, rd_data_reg.start};
    assign range_hi   = {1'b0, rd_data_reg.start} + {1'b0, rd_data_reg.length};
    assign target_ext = {1'b0, target_reg};
    assign range_hit  = (target_ext >= range_lo) && (target_ext < range_hi);

    assign is_func    = (info_reg[3:0] == FUNC_SYM_TYPE);
    assign table_full = (used_reg >= CNT_W'(TABLE_DEPTH));

    // sequencer outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        rd_en    = (state_reg == ST_SCAN) && (rd_idx_reg < used_reg);
        mem_we   = (state_reg == ST_LOAD) && is_func && !table_full;
        out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    assign in_accept = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    case (s_operation)
                        OP_LOAD:   state_next = ST_LOAD;
                        OP_CALL:   state_next = ST_SCAN;
                        OP_RETURN: state_next = ST_SCAN;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                // stop on the first hit, or once every stored entry has been compared
                if ((cmp_valid_reg && range_hit) || (!rd_en && !cmp_valid_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        used_next        = used_reg;
        depth_next       = depth_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        res_hit_next     = res_hit_reg;
        res_name_next    = res_name_reg;
        res_start_next   = res_start_reg;
        res_length_next  = res_length_reg;
        res_stored_next  = res_stored_reg;
        res_dropped_next = res_dropped_reg;

        if (in_accept) begin
            rd_idx_next      = '0;
            cmp_valid_next   = 1'b0;
            res_hit_next     = 1'b0;
            res_name_next    = '0;
            res_start_next   = '0;
            res_length_next  = '0;
            res_stored_next  = 1'b0;
            res_dropped_next = 1'b0;
        end

        if (state_reg == ST_LOAD && is_func) begin
            if (!table_full) begin
                used_next       = used_reg + CNT_W'(1);
                res_stored_next = 1'b1;
            end else begin
                res_dropped_next = 1'b1;
            end
        end

        if (state_reg == ST_SCAN) begin
            cmp_valid_next = rd_en;
            if (rd_en) begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (cmp_valid_reg && range_hit) begin
                res_hit_next    = 1'b1;
                res_name_next   = rd_data_reg.name;
                res_start_next  = rd_data_reg.start;
                res_length_next = rd_data_reg.length;
                // saturating depth step, only on a hit
                if (op_reg == OP_CALL) begin
                    if (depth_reg != DEPTH_MAX) begin
                        depth_next = depth_reg + 16'sd1;
                    end
                end else begin
                    if (depth_reg != DEPTH_MIN) begin
                        depth_next = depth_reg - 16'sd1;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            depth_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            depth_reg     <= depth_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg     <= s_operation;
            info_reg   <= s_symbol_info_byte;
            name_reg   <= s_symbol_name_offset;
            start_reg  <= s_symbol_start;
            length_reg <= s_symbol_length;
            target_reg <= s_target_address;
            pc_reg     <= s_trace_pc;
        end
        res_hit_reg     <= res_hit_next;
        res_name_reg    <= res_name_next;
        res_start_reg   <= res_start_next;
        res_length_reg  <= res_length_next;
        res_stored_reg  <= res_stored_next;
        res_dropped_reg <= res_dropped_next;
        if (out_load) begin
            m_hit_reg     <= res_hit_reg;
            m_name_reg    <= res_name_reg;
            m_start_reg   <= res_start_reg;
            m_length_reg  <= res_length_reg;
            m_depth_reg   <= depth_reg;
            m_pc_reg      <= pc_reg;
            m_stored_reg  <= res_stored_reg;
            m_dropped_reg <= res_dropped_reg;
        end
    end

    // table: one write port for loads, one registered read port for the scan
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[used_reg[IDX_W-1:0]] <= '{name: name_reg, start: start_reg, length: length_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_hit_name_offset = m_name_reg;
    assign m_hit_start       = m_start_reg;
    assign m_hit_length      = m_length_reg;
    assign m_depth_now       = m_depth_reg;
    assign m_pc_echo         = m_pc_reg;
    assign m_stored          = m_stored_reg;
    assign m_dropped_full    = m_dropped_reg;

endmodule

### hw/rtl/frlct_checker.sv
// port-level assertions for the function-range lookup call tracker, with bind
module frlct_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_operation,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_hit,
    input logic [31:0]        m_hit_name_offset,
    input logic [31:0]        m_hit_start,
    input logic [31:0]        m_hit_length,
    input logic signed [15:0] m_depth_now,
    input logic [31:0]        m_pc_echo,
    input logic               m_stored,
    input logic               m_dropped_full
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_depth_now) && $stable(m_pc_echo)
            && $stable(m_hit))
        else $error("stalled result beat changed");

    // an accepted beat occupies the sequencer for at least the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in work");

    // stored and dropped are exclusive, and neither comes with a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stored && m_dropped_full) && !(m_hit && (m_stored || m_dropped_full)))
        else $error("conflicting result flags");

    // a result without a hit carries a zero entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_hit_name_offset == 32'd0 && m_hit_start == 32'd0
            && m_hit_length == 32'd0)
        else $error("miss result carries entry data");

endmodule

bind func_range_lookup_call_tracker frlct_checker u_frlct_checker (.*);
